@@ hw/rtl/fpr_pkg.sv @@
// Shared types and constants for the FTP passive reply parser.
// Used by every module of the block; depends on nothing else.
package fpr_pkg;

  // Character codes that steer the parse.
  localparam logic [7:0] OPEN_PAREN  = 8'h28;
  localparam logic [7:0] CLOSE_PAREN = 8'h29;
  localparam logic [7:0] DIGIT_ZERO  = 8'h30;
  localparam logic [7:0] DIGIT_NINE  = 8'h39;
  localparam logic [7:0] NUL_BYTE    = 8'h00;

  // Count of numbers in a well-formed reply.
  localparam logic [2:0] NUMBER_COUNT = 3'd6;

  // Scan phase codes.
  localparam logic [1:0] PH_SEEK    = 2'd0;
  localparam logic [1:0] PH_COLLECT = 2'd1;
  localparam logic [1:0] PH_DONE    = 2'd2;

  // Default depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // One input item: a character of reply text.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } req_item_t;

  // One result item.
  typedef struct packed {
    logic        parse_ok;
    logic [31:0] server_address;
    logic [15:0] pasv_port;
  } rsp_item_t;

  // A character after classification by the front.
  typedef struct packed {
    logic       final_byte;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_open;
    logic       is_close;
    logic       is_nul;
  } fpr_class_t;

  // Parse status reported by the back.
  typedef struct packed {
    logic [1:0] scan_phase;
    logic [2:0] numbers_seen;
  } fpr_status_t;

endpackage

@@ hw/rtl/ftp_passive_reply_parser.sv @@
// FTP passive reply parser: takes reply text one character per item and gives one result
// on each item marked final. It accepts one character every cycle for as long as the
// result side keeps up; the back handles one character per cycle unless a final character
// waits for the output slot, and its multiply-by-ten and number packing are combinational.
// A result passes the front register, the queue and the output register on its way out.
// The queue of QUEUE_DEPTH entries lets the front keep taking characters while a result
// waits at the output. Characters before the first '(' are skipped, any non-digit
// separates numbers, ')' or the sixth number ends collection, and a zero ends the scan.
module ftp_passive_reply_parser #(
  parameter int QUEUE_DEPTH = fpr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  fpr_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output fpr_pkg::rsp_item_t rsp
);
  import fpr_pkg::*;

  logic        push_valid;
  fpr_class_t  push_item;
  logic        q_full;
  logic        q_valid;
  fpr_class_t  q_item;
  logic        q_take;
  fpr_status_t status;

  fpr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .push_valid (push_valid),
    .push_item  (push_item),
    .q_full     (q_full)
  );

  fpr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop_take   (q_take)
  );

  fpr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .status    (status)
  );

`ifndef ASSERT_OFF
  // The count of finished numbers never passes six.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    status.numbers_seen <= NUMBER_COUNT)
    else $error("numbers_seen beyond six");

  // Six finished numbers always close the collection.
  a_six_done: assert property (@(posedge clk) disable iff (rst)
    status.numbers_seen == NUMBER_COUNT |-> status.scan_phase == PH_DONE)
    else $error("six numbers seen but scan still open");

  // The front only stalls the input while it holds an item for a full queue.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (push_valid && q_full))
    else $error("input stalled without a waiting item");

  // The back takes nothing from an empty queue.
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    q_take |-> q_valid)
    else $error("take from empty queue");
`endif

endmodule

@@ hw/rtl/fpr_front.sv @@
// Front of the FTP passive reply parser: accepts characters and classifies them.
// Depends on fpr_pkg; feeds fpr_queue.
module fpr_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  fpr_pkg::req_item_t req,
  output logic               push_valid,
  output fpr_pkg::fpr_class_t push_item,
  input  logic               q_full
);
  import fpr_pkg::*;

  logic       hold_valid;
  fpr_class_t hold_item;
  fpr_class_t cls;

  // The held item waits only while the queue is full.
  assign req_stall  = hold_valid && q_full;
  assign push_valid = hold_valid;
  assign push_item  = hold_item;

  // Classify the incoming character.
  always_comb begin
    cls.final_byte = req.final_byte;
    cls.is_digit   = (req.text_byte >= DIGIT_ZERO) && (req.text_byte <= DIGIT_NINE);
    cls.digit      = req.text_byte[3:0];
    cls.is_open    = (req.text_byte == OPEN_PAREN);
    cls.is_close   = (req.text_byte == CLOSE_PAREN);
    cls.is_nul     = (req.text_byte == NUL_BYTE);
  end

  // Holding register in front of the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!req_stall) begin
      hold_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      hold_item <= cls;
    end
  end

endmodule

@@ hw/rtl/fpr_queue.sv @@
// Short queue of classified characters between the front and the back.
// Depends on fpr_pkg.
module fpr_queue #(
  parameter int DEPTH = fpr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  fpr_pkg::fpr_class_t push_item,
  output logic                full,
  output logic                pop_valid,
  output fpr_pkg::fpr_class_t pop_item,
  input  logic                pop_take
);
  import fpr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  fpr_class_t    slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == FULL_COUNT);
  assign pop_valid = (count != '0);
  assign pop_item  = slots[rd_ptr];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop_take && pop_valid;

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

@@ hw/rtl/fpr_back.sv @@
// Back of the FTP passive reply parser: runs the scan and builds the result.
// Depends on fpr_pkg; fed by fpr_queue.
module fpr_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  fpr_pkg::fpr_class_t q_item,
  output logic                q_take,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output fpr_pkg::rsp_item_t  rsp,
  output fpr_pkg::fpr_status_t status
);
  import fpr_pkg::*;

  logic [1:0]  scan_phase;
  logic [2:0]  numbers_seen;
  logic        in_number;
  logic [31:0] number_acc;
  logic [31:0] address_acc;
  logic [15:0] port_acc;

  logic        collecting;
  logic [31:0] acc_step;
  logic [31:0] finish_val;
  logic        finish_en;
  logic [31:0] address_fin;
  logic [15:0] port_fin;
  logic [2:0]  count_fin;
  logic [1:0]  scan_phase_next;
  logic        in_number_next;
  logic [31:0] number_acc_next;
  logic [31:0] address_acc_next;
  logic [15:0] port_acc_next;
  logic [2:0]  numbers_seen_next;

  // A final item needs the output slot; other items never wait.
  assign q_take = q_valid && (!q_item.final_byte || !rsp_valid || !rsp_stall);

  assign status.scan_phase   = scan_phase;
  assign status.numbers_seen = numbers_seen;

  assign collecting = (scan_phase == PH_COLLECT);

  // Times ten plus the new digit, modulo 2^32.
  assign acc_step = (number_acc << 3) + (number_acc << 1) + {28'd0, q_item.digit};

  // A number ends on a non-digit, or on the final item while still open.
  assign finish_val = q_item.is_digit ? acc_step : number_acc;
  assign finish_en  = q_take && collecting &&
                      (q_item.is_digit ? q_item.final_byte : in_number);
  assign count_fin  = numbers_seen + 3'd1;

  // Place the finished number into the address or the port.
  always_comb begin
    address_fin = address_acc;
    port_fin    = port_acc;
    case (numbers_seen)
      3'd0: address_fin = address_acc | (finish_val << 24);
      3'd1: address_fin = address_acc | (finish_val << 16);
      3'd2: address_fin = address_acc | (finish_val << 8);
      3'd3: address_fin = address_acc | finish_val;
      3'd4: port_fin    = port_acc + {finish_val[7:0], 8'd0};
      3'd5: port_fin    = port_acc + finish_val[15:0];
      default: begin
        address_fin = address_acc;
        port_fin    = port_acc;
      end
    endcase
  end

  // Next scan state for one character.
  always_comb begin
    scan_phase_next   = scan_phase;
    in_number_next    = in_number;
    number_acc_next   = number_acc;
    address_acc_next  = address_acc;
    port_acc_next     = port_acc;
    numbers_seen_next = numbers_seen;
    case (scan_phase)
      PH_SEEK: begin
        if (q_item.is_nul) begin
          scan_phase_next = PH_DONE;
        end else if (q_item.is_open) begin
          scan_phase_next = PH_COLLECT;
        end
      end
      PH_COLLECT: begin
        if (q_item.is_digit) begin
          number_acc_next = acc_step;
          in_number_next  = 1'b1;
        end else if (q_item.is_nul || q_item.is_close) begin
          scan_phase_next = PH_DONE;
        end
        if (finish_en) begin
          address_acc_next  = address_fin;
          port_acc_next     = port_fin;
          numbers_seen_next = count_fin;
          in_number_next    = 1'b0;
          number_acc_next   = '0;
          if (count_fin >= NUMBER_COUNT) begin
            scan_phase_next = PH_DONE;
          end
        end
      end
      default: begin
        scan_phase_next = scan_phase;
      end
    endcase
  end

  // Scan state; a final item returns it to the starting point.
  always_ff @(posedge clk) begin
    if (rst || (q_take && q_item.final_byte)) begin
      scan_phase   <= PH_SEEK;
      numbers_seen <= '0;
      in_number    <= 1'b0;
      number_acc   <= '0;
      address_acc  <= '0;
      port_acc     <= '0;
    end else if (q_take) begin
      scan_phase   <= scan_phase_next;
      numbers_seen <= numbers_seen_next;
      in_number    <= in_number_next;
      number_acc   <= number_acc_next;
      address_acc  <= address_acc_next;
      port_acc     <= port_acc_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (q_take && q_item.final_byte) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take && q_item.final_byte) begin
      rsp.parse_ok       <= (numbers_seen_next == NUMBER_COUNT);
      rsp.server_address <= address_acc_next;
      rsp.pasv_port      <= port_acc_next;
    end
  end

endmodule
